/* rtl/csvtok_pkg.sv */
// csvtok_pkg: shared types and constants of the csv quoted field tokenizer
// no dependencies; imported by every module, not by the interfaces
`default_nettype none

package csvtok_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_AFTER_QUOTE = 2'd1;
    localparam logic [1:0] ERR_STRAY_QUOTE = 2'd2;
    localparam logic [1:0] ERR_UNTERM     = 2'd3;

    localparam int QUEUE_DEPTH_DEF = 2;

    // byte class as decided by the front end
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_QUOTE,
        CLS_COMMA,
        CLS_CR,
        CLS_LF,
        CLS_END
    } class_t;

    typedef struct packed {
        class_t     cls;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic       field_end;
        logic       row_end;
        logic [1:0] error_code;
    } result_t;

    // queue handshake between front and back
    typedef struct packed {
        logic valid;
        logic ready;
    } qctl_t;

endpackage

`default_nettype wire

/* rtl/csvtok_in_if.sv */
// csvtok_in_if: input channel carrying one text byte or the end marker per beat
// depends on nothing
`default_nettype none

interface csvtok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

/* rtl/csvtok_out_if.sv */
// csvtok_out_if: result channel, one token beat per input beat
// depends on nothing
`default_nettype none

interface csvtok_out_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] char_out;
    logic       field_end;
    logic       row_end;
    logic [1:0] error_code;

    modport source (output valid, output char_valid, output char_out, output field_end,
                    output row_end, output error_code, input ready);
    modport sink   (input valid, input char_valid, input char_out, input field_end,
                    input row_end, input error_code, output ready);
endinterface

`default_nettype wire

/* rtl/csvtok_front.sv */
// csvtok_front: accepts input beats and classifies each byte for the back end
// depends on csvtok_pkg and csvtok_in_if
`default_nettype none

module csvtok_front
    import csvtok_pkg::*;
(
    csvtok_in_if.sink   text,
    output item_t       push_item,
    output qctl_t       push_ctl_out,
    input  logic        push_ready
);

    class_t cls;

    always_comb
    begin
        if (text.end_of_input)
        begin
            cls = CLS_END;
        end
        else
        begin
            unique case (text.in_byte)
                CH_QUOTE: cls = CLS_QUOTE;
                CH_COMMA: cls = CLS_COMMA;
                CH_CR:    cls = CLS_CR;
                CH_LF:    cls = CLS_LF;
                default:  cls = CLS_OTHER;
            endcase
        end
    end

    assign push_item.cls     = cls;
    assign push_item.data    = text.in_byte;
    assign push_ctl_out.valid = text.valid;
    assign push_ctl_out.ready = push_ready;
    assign text.ready        = push_ready;

endmodule

`default_nettype wire

/* rtl/csvtok_queue.sv */
// csvtok_queue: short fifo of classified items between front and back
// depends on csvtok_pkg
`default_nettype none

module csvtok_queue
    import csvtok_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  qctl_t push_ctl,
    input  item_t push_item,
    output logic  push_ready,
    output qctl_t pop_ctl_out,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    item_t           store_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != FullCnt);
    assign do_push    = push_ctl.valid && push_ready;
    assign do_pop     = (count_reg != '0) && pop_ready;

    assign pop_ctl_out.valid = (count_reg != '0);
    assign pop_ctl_out.ready = pop_ready;
    assign pop_item          = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/csvtok_back.sv */
// csvtok_back: parser state machine and registered result stage
// depends on csvtok_pkg and csvtok_out_if
`default_nettype none

module csvtok_back
    import csvtok_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  qctl_t        pop_ctl,
    input  item_t        pop_item,
    output logic         pop_ready,
    csvtok_out_if.source tokens
);

    localparam logic [1:0] MODE_UNQUOTED = 2'd0;
    localparam logic [1:0] MODE_QUOTED   = 2'd1;
    localparam logic [1:0] MODE_PENDING  = 2'd2;

    logic [1:0] mode_reg, mode_next;
    logic       acq_reg, acq_next;
    logic       crp_reg, crp_next;
    logic       fhd_reg, fhd_next;
    logic       rhf_reg, rhf_next;
    logic [1:0] err_reg, err_next;
    logic       ovalid_reg, ovalid_next;
    result_t    res_reg, res_next;
    logic       take;

    // result stage frees up when empty or drained this cycle
    assign pop_ready = !ovalid_reg || tokens.ready;
    assign take      = pop_ctl.valid && pop_ready;

    always_comb
    begin
        logic done;
        done      = 1'b0;
        mode_next = mode_reg;
        acq_next  = acq_reg;
        crp_next  = crp_reg;
        fhd_next  = fhd_reg;
        rhf_next  = rhf_reg;
        err_next  = err_reg;
        res_next  = '0;

        if (pop_item.cls == CLS_END)
        begin
            if (err_reg != ERR_NONE)
            begin
                res_next.error_code = err_reg;
            end
            else if (mode_reg == MODE_QUOTED)
            begin
                res_next.error_code = ERR_UNTERM;
            end
            else if (fhd_reg || rhf_reg || acq_reg || (mode_reg == MODE_PENDING))
            begin
                res_next.field_end = 1'b1;
                res_next.row_end   = 1'b1;
            end
            mode_next = MODE_UNQUOTED;
            acq_next  = 1'b0;
            crp_next  = 1'b0;
            fhd_next  = 1'b0;
            rhf_next  = 1'b0;
            err_next  = ERR_NONE;
        end
        else if (err_reg != ERR_NONE)
        begin
            res_next.error_code = err_reg;
        end
        else if (mode_reg == MODE_QUOTED)
        begin
            crp_next = 1'b0;
            if (pop_item.cls == CLS_QUOTE)
            begin
                mode_next = MODE_PENDING;
            end
            else
            begin
                res_next.char_valid = 1'b1;
                res_next.char_out   = pop_item.data;
                fhd_next            = 1'b1;
            end
        end
        else
        begin
            // pending quote: doubled quote or closing quote
            if (mode_reg == MODE_PENDING)
            begin
                crp_next = 1'b0;
                if (pop_item.cls == CLS_QUOTE)
                begin
                    mode_next           = MODE_QUOTED;
                    fhd_next            = 1'b1;
                    res_next.char_valid = 1'b1;
                    res_next.char_out   = CH_QUOTE;
                    done                = 1'b1;
                end
                else
                begin
                    acq_next = 1'b1;
                end
            end
            if (!done)
            begin
                mode_next = MODE_UNQUOTED;
                // lf right after cr is swallowed
                if (crp_next)
                begin
                    crp_next = 1'b0;
                    if (pop_item.cls == CLS_LF)
                    begin
                        done = 1'b1;
                    end
                end
            end
            if (!done)
            begin
                if (acq_next && !(pop_item.cls inside {CLS_COMMA, CLS_CR, CLS_LF}))
                begin
                    err_next = ERR_AFTER_QUOTE;
                end
                else
                begin
                    case (pop_item.cls) inside
                        CLS_QUOTE:
                        begin
                            if (fhd_reg || acq_next)
                                err_next = ERR_STRAY_QUOTE;
                            else
                                mode_next = MODE_QUOTED;
                        end
                        CLS_COMMA:
                        begin
                            res_next.field_end = 1'b1;
                            fhd_next           = 1'b0;
                            acq_next           = 1'b0;
                            rhf_next           = 1'b1;
                        end
                        CLS_CR, CLS_LF:
                        begin
                            res_next.field_end = 1'b1;
                            res_next.row_end   = 1'b1;
                            fhd_next           = 1'b0;
                            acq_next           = 1'b0;
                            rhf_next           = 1'b0;
                            crp_next           = (pop_item.cls == CLS_CR);
                        end
                        default:
                        begin
                            res_next.char_valid = 1'b1;
                            res_next.char_out   = pop_item.data;
                            fhd_next            = 1'b1;
                        end
                    endcase
                end
                res_next.error_code = err_next;
            end
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (take)
            ovalid_next = 1'b1;
        else if (tokens.ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_UNQUOTED;
            acq_reg    <= 1'b0;
            crp_reg    <= 1'b0;
            fhd_reg    <= 1'b0;
            rhf_reg    <= 1'b0;
            err_reg    <= ERR_NONE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            if (take)
            begin
                mode_reg <= mode_next;
                acq_reg  <= acq_next;
                crp_reg  <= crp_next;
                fhd_reg  <= fhd_next;
                rhf_reg  <= rhf_next;
                err_reg  <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

    assign tokens.valid      = ovalid_reg;
    assign tokens.char_valid = res_reg.char_valid;
    assign tokens.char_out   = res_reg.char_out;
    assign tokens.field_end  = res_reg.field_end;
    assign tokens.row_end    = res_reg.row_end;
    assign tokens.error_code = res_reg.error_code;

    a_row_implies_field: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && res_reg.row_end |-> res_reg.field_end)
        else $error("row end without field end");

    a_error_no_token: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && (res_reg.error_code != ERR_NONE)
        |-> !res_reg.char_valid && !res_reg.field_end)
        else $error("error beat carries token data");

    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != 2'd3)
        else $error("parse mode out of range");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && (pop_item.cls == CLS_END) |=> (mode_reg == MODE_UNQUOTED)
        && (err_reg == ERR_NONE) && !acq_reg && !crp_reg && !fhd_reg && !rhf_reg)
        else $error("end beat left parser state behind");

endmodule

`default_nettype wire

/* rtl/csv_quoted_field_tokenizer.sv */
// csv_quoted_field_tokenizer: top level, byte stream in, one token beat out per byte
// depends on csvtok_pkg, csvtok_in_if, csvtok_out_if, csvtok_front, csvtok_queue,
// csvtok_back
//
//  channel   dir  payload                                                  width
//  text      in   in_byte, end_of_input                                    8+1
//  tokens    out  char_valid, char_out, field_end, row_end, error_code     1+8+1+1+2
//
// one beat per cycle sustained while tokens is ready; a text beat is classified and
// written into the queue at its accepting edge, and the back end takes it from the
// queue head into the result register that drives tokens
// the parser state update in the back end is a registered loop and sets the rate
// rst_n clears parser state, queue pointers and the result valid at once
// a stall on tokens holds the result register; the queue then fills and text.ready
// drops once it is full, so the queue depth sets how much slack there is
`default_nettype none

module csv_quoted_field_tokenizer
    import csvtok_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    csvtok_in_if.sink    text,
    csvtok_out_if.source tokens
);

    // classified item on its way into the queue
    item_t push_item;
    qctl_t push_ctl;
    logic  push_ready;

    // head of the queue on its way into the parser
    item_t pop_item;
    qctl_t pop_ctl;
    logic  pop_ready;

    csvtok_front u_front (
        .text         (text),
        .push_item    (push_item),
        .push_ctl_out (push_ctl),
        .push_ready   (push_ready)
    );

    csvtok_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_ctl    (push_ctl),
        .push_item   (push_item),
        .push_ready  (push_ready),
        .pop_ctl_out (pop_ctl),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item)
    );

    // parser plus result register; it pulls from the queue whenever
    // its result slot is free or draining
    csvtok_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_ctl   (pop_ctl),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .tokens    (tokens)
    );

endmodule

`default_nettype wire
